>>> src/assert_macros.svh
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define PLTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plti: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define PLTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plti: next-cycle check failed");

`endif

>>> src/plti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package plti_pkg;

  localparam int IDX_W = 6;  // entry index / segment index width
  localparam int CNT_W = 7;  // entry_count register width

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // write one breakpoint
    logic query_ld;  // capture query operands
    logic scan_vld;  // RAM read data valid this cycle
    logic seg_ld;    // latch matched segment operands
    logic mul_step;  // one shift-add multiply step
    logic div_step;  // one restoring divide step
    logic out_hit;   // register interpolated result
    logic out_miss;  // register last entry's y
  } plti_cmd_t;

endpackage
`default_nettype wire

>>> src/plti_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module plti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/plti_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module plti_ctrl #(
  parameter int VALUE_WIDTH = 32,
  parameter int TABLE_DEPTH = 64,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_op,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [plti_pkg::CNT_W-1:0] cfg_entry_count,
  input  wire logic                       seg_hit,
  output plti_pkg::plti_cmd_t             cmd,
  output logic      [AW-1:0]              raddr,
  output logic                            out_valid,
  output logic                            out_interpolated,
  output logic      [plti_pkg::IDX_W-1:0] out_segment_index
);
  import plti_pkg::*;

  localparam int ML = VALUE_WIDTH + 1;
  localparam int SW = $clog2(2 * ML);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [SW-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0] entry_count_r;
  logic [AW-1:0]    last_r, last_nxt, last_c;
  logic [AW-1:0]    iss_r, iss_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]    seg_idx_r, seg_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_interp_r, out_interp_nxt;
  logic [IDX_W-1:0] out_seg_r, out_seg_nxt;
  logic             accept;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;
  assign raddr     = iss_r;

  assign out_valid         = out_valid_r;
  assign out_interpolated  = out_interp_r;
  assign out_segment_index = out_seg_r;

  // count of 0 acts as 1, above depth acts as depth
  always_comb begin
    if (entry_count_r == '0) begin
      last_c = '0;
    end else if (int'(entry_count_r) > TABLE_DEPTH) begin
      last_c = AW'(TABLE_DEPTH - 1);
    end else begin
      last_c = AW'(entry_count_r - 1'b1);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    last_nxt       = last_r;
    iss_nxt        = iss_r;
    iss_done_nxt   = iss_done_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    seg_idx_nxt    = seg_idx_r;
    out_valid_nxt  = 1'b0;
    out_interp_nxt = out_interp_r;
    out_seg_nxt    = out_seg_r;
    cmd            = '0;
    cmd.load       = accept & ~in_op;

    case (state_r)
      S_IDLE: begin
        if (accept & in_op) begin
          cmd.query_ld = 1'b1;
          last_nxt     = last_c;
          iss_nxt      = '0;
          iss_done_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue side: one read per cycle up to the last entry
        if (!iss_done_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = iss_r;
          if (iss_r == last_r) begin
            iss_done_nxt = 1'b1;
          end else begin
            iss_nxt = iss_r + 1'b1;
          end
        end
        // check side: data of entry rd_idx_r closes segment rd_idx_r-1
        if (rd_vld_r) begin
          cmd.scan_vld = 1'b1;
          if ((rd_idx_r != '0) && seg_hit) begin
            cmd.seg_ld  = 1'b1;
            seg_idx_nxt = rd_idx_r - 1'b1;
            cnt_nxt     = '0;
            rd_vld_nxt  = 1'b0;
            state_nxt   = S_MUL;
          end else if (rd_idx_r == last_r) begin
            cmd.out_miss   = 1'b1;
            out_valid_nxt  = 1'b1;
            out_interp_nxt = 1'b0;
            out_seg_nxt    = IDX_W'(rd_idx_r);
            rd_vld_nxt     = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == SW'(ML - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == SW'(2 * ML - 1)) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.out_hit    = 1'b1;
        out_valid_nxt  = 1'b1;
        out_interp_nxt = 1'b1;
        out_seg_nxt    = IDX_W'(seg_idx_r);
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= CNT_W'(1);
      iss_done_r    <= 1'b0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_done_r  <= iss_done_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid & cfg_ready) begin
        entry_count_r <= cfg_entry_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    last_r       <= last_nxt;
    iss_r        <= iss_nxt;
    rd_idx_r     <= rd_idx_nxt;
    seg_idx_r    <= seg_idx_nxt;
    out_interp_r <= out_interp_nxt;
    out_seg_r    <= out_seg_nxt;
  end

endmodule
`default_nettype wire

>>> src/plti_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module plti_dp #(
  parameter int VALUE_WIDTH = 32,
  parameter int TABLE_DEPTH = 64,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  wire logic                          clk,
  input  wire plti_pkg::plti_cmd_t           cmd,
  input  wire logic        [AW-1:0]          raddr,
  input  wire logic [plti_pkg::IDX_W-1:0]    in_entry_index,
  input  wire logic signed [VALUE_WIDTH-1:0] in_entry_x,
  input  wire logic signed [VALUE_WIDTH-1:0] in_entry_y,
  input  wire logic signed [VALUE_WIDTH-1:0] in_query_x,
  input  wire logic signed [VALUE_WIDTH-1:0] in_floor_value,
  output logic                               seg_hit,
  output logic signed      [VALUE_WIDTH-1:0] out_value
);
  import plti_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int ML = VW + 1;   // difference / magnitude width
  localparam int PW = 2 * ML;   // product / dividend width

  logic                 we;
  logic [AW-1:0]        waddr;
  logic signed [VW-1:0] rx, ry;

  logic signed [VW-1:0] qx_r, fl_r, px_r, py_r, y0_r, out_value_r;
  logic [ML-1:0]        a_r, d_r, rem_r;
  logic                 neg_r;
  logic [PW:0]          mp_r;

  logic                 x_hit;
  logic [ML-1:0]        dy, dq, den, dy_mag, dq_mag, den_mag;
  logic                 neg;
  logic [ML:0]          mul_sum;
  logic [PW:0]          mp_mul_nxt, mp_div_nxt;
  logic [ML:0]          div_t, div_diff;
  logic                 div_ge;
  logic [ML-1:0]        rem_div_nxt;
  logic [ML:0]          q_ext, q_sgn, y0_ext, fin_sum;

  // loads beyond the table are dropped
  assign we    = cmd.load & (32'(in_entry_index) < TABLE_DEPTH);
  assign waddr = AW'(in_entry_index);

  plti_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_ram_x (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_entry_x),
    .raddr (raddr),
    .rdata (rx)
  );

  plti_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_ram_y (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_entry_y),
    .raddr (raddr),
    .rdata (ry)
  );

  // segment (prev, current): rising [x0, x1) or falling (x1, x0]
  assign x_hit   = ((px_r <= qx_r) && (qx_r < rx)) || ((px_r >= qx_r) && (qx_r > rx));
  assign seg_hit = x_hit && (fl_r < ry);

  assign dy  = {ry[VW-1], ry} - {py_r[VW-1], py_r};
  assign dq  = {qx_r[VW-1], qx_r} - {px_r[VW-1], px_r};
  assign den = {rx[VW-1], rx} - {px_r[VW-1], px_r};

  assign dy_mag  = dy[ML-1]  ? (~dy + 1'b1)  : dy;
  assign dq_mag  = dq[ML-1]  ? (~dq + 1'b1)  : dq;
  assign den_mag = den[ML-1] ? (~den + 1'b1) : den;
  assign neg     = dy[ML-1] ^ dq[ML-1] ^ den[ML-1];

  // shift-add multiply: upper half accumulates, multiplier shifts out below
  assign mul_sum    = mp_r[PW:ML] + (mp_r[0] ? {1'b0, a_r} : {(ML+1){1'b0}});
  assign mp_mul_nxt = {1'b0, mul_sum, mp_r[ML-1:1]};

  // restoring divide: dividend shifts out the top, quotient bits in below
  assign div_t       = {rem_r, mp_r[PW-1]};
  assign div_diff    = div_t - {1'b0, d_r};
  assign div_ge      = (div_t >= {1'b0, d_r});
  assign rem_div_nxt = div_ge ? div_diff[ML-1:0] : div_t[ML-1:0];
  assign mp_div_nxt  = {1'b0, mp_r[PW-2:0], div_ge};

  assign q_ext   = {1'b0, mp_r[ML-1:0]};
  assign q_sgn   = neg_r ? (~q_ext + 1'b1) : q_ext;
  assign y0_ext  = {{2{y0_r[VW-1]}}, y0_r};
  assign fin_sum = y0_ext + q_sgn;

  always_ff @(posedge clk) begin
    if (cmd.query_ld) begin
      qx_r <= in_query_x;
      fl_r <= in_floor_value;
    end
    if (cmd.scan_vld) begin
      px_r <= rx;
      py_r <= ry;
    end
    if (cmd.seg_ld) begin
      a_r   <= dy_mag;
      d_r   <= den_mag;
      neg_r <= neg;
      y0_r  <= py_r;
      mp_r  <= {{(ML+1){1'b0}}, dq_mag};
      rem_r <= '0;
    end else if (cmd.mul_step) begin
      mp_r <= mp_mul_nxt;
    end else if (cmd.div_step) begin
      mp_r  <= mp_div_nxt;
      rem_r <= rem_div_nxt;
    end
    if (cmd.out_hit) begin
      out_value_r <= fin_sum[VW-1:0];
    end else if (cmd.out_miss) begin
      out_value_r <= ry;
    end
  end

  assign out_value = out_value_r;

endmodule
`default_nettype wire

>>> src/piecewise_linear_table_interp.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------------
// request  | start, busy               | in_op, in_entry_index, in_entry_x, in_entry_y,
//          |                           | in_query_x, in_floor_value
// result   | out_valid (1-cycle strobe)| out_value, out_interpolated, out_segment_index
// config   | cfg_valid, cfg_ready      | cfg_entry_count
//
// Load request: writes the breakpoint RAMs in the accept cycle, no result, busy stays low.
// Query request: scan reads one entry per cycle; a miss over n entries strobes after
//   entry n-1 is checked. A hit on segment i adds VALUE_WIDTH+1 shift-add multiply
//   steps and 2*(VALUE_WIDTH+1) restoring divide steps, then registers the result.
// Reset (rst_n, synchronous): entry_count = 1, controller idle; table contents undefined.
// The result side has no back-pressure; a new request may be accepted in the strobe cycle.
module piecewise_linear_table_interp #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_op,
  input  wire logic [plti_pkg::IDX_W-1:0]    in_entry_index,
  input  wire logic signed [VALUE_WIDTH-1:0] in_entry_x,
  input  wire logic signed [VALUE_WIDTH-1:0] in_entry_y,
  input  wire logic signed [VALUE_WIDTH-1:0] in_query_x,
  input  wire logic signed [VALUE_WIDTH-1:0] in_floor_value,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [plti_pkg::CNT_W-1:0]    cfg_entry_count,
  // result channel
  output logic                               out_valid,
  output logic signed      [VALUE_WIDTH-1:0] out_value,
  output logic                               out_interpolated,
  output logic      [plti_pkg::IDX_W-1:0]    out_segment_index
);
  import plti_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  plti_cmd_t     cmd;
  logic [AW-1:0] raddr;
  logic          seg_hit;

  // controller: scan sequencing, multiply/divide step count, result strobe
  plti_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_entry_count   (cfg_entry_count),
    .seg_hit           (seg_hit),
    .cmd               (cmd),
    .raddr             (raddr),
    .out_valid         (out_valid),
    .out_interpolated  (out_interpolated),
    .out_segment_index (out_segment_index)
  );

  // datapath: breakpoint RAMs, segment test, serial multiply and divide
  plti_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .raddr          (raddr),
    .in_entry_index (in_entry_index),
    .in_entry_x     (in_entry_x),
    .in_entry_y     (in_entry_y),
    .in_query_x     (in_query_x),
    .in_floor_value (in_floor_value),
    .seg_hit        (seg_hit),
    .out_value      (out_value)
  );

endmodule
`default_nettype wire

>>> src/plti_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module plti_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_op,
  input wire logic out_valid
);

  // results never come in adjacent cycles
  `PLTI_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  // a result strobe means the engine is already free
  `PLTI_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy)
  // an accepted query occupies the engine
  `PLTI_ASSERT_NXT(a_query_busy, clk, rst_n, start && !busy && in_op, busy)
  // a load completes in its accept cycle
  `PLTI_ASSERT_NXT(a_load_free, clk, rst_n, start && !busy && !in_op, !busy && !out_valid)

endmodule

bind piecewise_linear_table_interp plti_checker u_plti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_op     (in_op),
  .out_valid (out_valid)
);
`default_nettype wire

>>> bench/tb_piecewise_linear_table_interp.sv
`timescale 1ns / 1ps
module tb_piecewise_linear_table_interp;
  import plti_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int N_PHASES = 12;
  localparam int REQS_PER_PHASE = 22;

  localparam logic signed [VALUE_WIDTH-1:0] MAX_Q = 32'h7FFF_FFFF;
  localparam logic signed [VALUE_WIDTH-1:0] MIN_Q = 32'h8000_0000;

  typedef enum logic {OP_LOAD = 1'b0, OP_QUERY = 1'b1} req_op_e;
  typedef enum logic {ROW_REQ = 1'b0, ROW_CFG = 1'b1} row_kind_e;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          interpolated;
    logic [IDX_W-1:0]              segment_index;
  } interp_answer_t;

  // One directed step: either a request or an entry_count write. Where
  // has_want is set the answer is typed in; otherwise the predictor decides.
  typedef struct packed {
    row_kind_e        kind;
    req_op_e          op;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic [31:0]      ex;
    logic [31:0]      ey;
    logic [31:0]      qx;
    logic [31:0]      fl;
    logic             has_want;
    logic [31:0]      want_value;
    logic             want_interp;
    logic [IDX_W-1:0] want_seg;
  } stim_row_t;

  localparam int N_ROWS = 24;
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    // single entry after reset: no segment, last entry returned
    '{ROW_REQ, OP_LOAD,  6'd0,  7'd0, 32'h0, MAX_Q, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 6'd0},
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, MIN_Q, MIN_Q, 1'b1, MAX_Q, 1'b0, 6'd0},
    // count zero behaves as one
    '{ROW_CFG, OP_LOAD,  6'd0,  7'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 6'd0},
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, MAX_Q, MAX_Q, 1'b1, MAX_Q, 1'b0, 6'd0},
    // inside the segment but floor equals the upper y: no match
    '{ROW_REQ, OP_LOAD,  6'd1,  7'd0, MAX_Q, MIN_Q, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 6'd0},
    '{ROW_CFG, OP_LOAD,  6'd0,  7'd2, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 6'd0},
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, 32'h4000_0000, MIN_Q,
      1'b1, MIN_Q, 1'b0, 6'd1},
    // full-range rising segment
    '{ROW_REQ, OP_LOAD,  6'd0,  7'd0, MIN_Q, MIN_Q, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 6'd0},
    '{ROW_REQ, OP_LOAD,  6'd1,  7'd0, MAX_Q, MAX_Q, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 6'd0},
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, MIN_Q, MIN_Q, 1'b1, MIN_Q, 1'b1, 6'd0},
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 6'd0},
    // upper x is excluded on a rising segment
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, MAX_Q, MIN_Q, 1'b1, MAX_Q, 1'b0, 6'd1},
    // floor at the top blocks every segment
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, 32'h1234_5678, MAX_Q,
      1'b1, MAX_Q, 1'b0, 6'd1},
    // full-range falling segment: upper x end included, far end excluded
    '{ROW_REQ, OP_LOAD,  6'd0,  7'd0, MAX_Q, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 6'd0},
    '{ROW_REQ, OP_LOAD,  6'd1,  7'd0, MIN_Q, 32'h0001_0000, 32'h0, 32'h0,
      1'b0, 32'h0, 1'b0, 6'd0},
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, MAX_Q, MIN_Q, 1'b1, 32'h0, 1'b1, 6'd0},
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, MIN_Q, MIN_Q,
      1'b1, 32'h0001_0000, 1'b0, 6'd1},
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
      1'b0, 32'h0, 1'b0, 6'd0},
    // third entry, plus the top slot
    '{ROW_REQ, OP_LOAD,  6'd2,  7'd0, 32'hFFFF_0000, 32'h0003_0000, 32'h0, 32'h0,
      1'b0, 32'h0, 1'b0, 6'd0},
    '{ROW_REQ, OP_LOAD,  6'd63, 7'd0, MAX_Q, MIN_Q, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 6'd0},
    '{ROW_CFG, OP_LOAD,  6'd0,  7'd3, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 6'd0},
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, 32'hC000_0000, 32'h0003_0000,
      1'b1, 32'h0003_0000, 1'b0, 6'd2},
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, 32'hC000_0000, MIN_Q,
      1'b0, 32'h0, 1'b0, 6'd0},
    // first segment blocked by the floor, second one taken
    '{ROW_REQ, OP_QUERY, 6'd0,  7'd0, 32'h0, 32'h0, 32'hFFFE_0000, 32'h0001_0000,
      1'b0, 32'h0, 1'b0, 6'd0}
  };

  // entry_count per random phase; 0 and 127 are the clamped extremes
  localparam int PHASE_COUNT [N_PHASES] = '{2, 5, 64, 3, 1, 8, 127, 4, 0, 12, 2, 6};
  // sender idle percentage, one per group of four phases
  localparam int STAGE_IDLE [3] = '{29, 46, 0};

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_op = 1'b0;
  logic [IDX_W-1:0]              in_entry_index = '0;
  logic signed [VALUE_WIDTH-1:0] in_entry_x = '0;
  logic signed [VALUE_WIDTH-1:0] in_entry_y = '0;
  logic signed [VALUE_WIDTH-1:0] in_query_x = '0;
  logic signed [VALUE_WIDTH-1:0] in_floor_value = '0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CNT_W-1:0]              cfg_entry_count = '0;
  logic                          out_valid;
  logic signed [VALUE_WIDTH-1:0] out_value;
  logic                          out_interpolated;
  logic [IDX_W-1:0]              out_segment_index;

  // shadow of the breakpoint table and the count register
  logic signed [VALUE_WIDTH-1:0] bp_x [TABLE_DEPTH];
  logic signed [VALUE_WIDTH-1:0] bp_y [TABLE_DEPTH];
  bit                            entry_loaded [TABLE_DEPTH];
  logic [CNT_W-1:0]              entry_count_q = 7'd1;

  interp_answer_t answers_due [$];
  interp_answer_t got_want;
  int             mismatches = 0;
  int             cycle_count = 0;
  int             idle_pct = 0;

  piecewise_linear_table_interp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_entry_index    (in_entry_index),
    .in_entry_x        (in_entry_x),
    .in_entry_y        (in_entry_y),
    .in_query_x        (in_query_x),
    .in_floor_value    (in_floor_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_entry_count   (cfg_entry_count),
    .out_valid         (out_valid),
    .out_value         (out_value),
    .out_interpolated  (out_interpolated),
    .out_segment_index (out_segment_index)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run guard: a hung handshake ends the test as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // entries in use after clamping: 0 acts as 1, above the depth acts as the depth
  function automatic int active_entries();
    int n;
    n = int'(entry_count_q);
    if (n < 1) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  // First qualifying segment wins; interpolation is exact with the quotient
  // truncated toward zero, done on magnitudes and signed afterwards.
  function automatic interp_answer_t predict_interp(input logic signed [31:0] qx,
                                                    input logic signed [31:0] fl);
    interp_answer_t ans;
    longint         x0, x1, y0, y1, dy, dq, den, qxl, fll, v;
    logic [65:0]    mag_dy, mag_dq, mag_den, quo;
    int             n;
    bit             found;
    n = active_entries();
    qxl = qx;
    fll = fl;
    ans.value = bp_y[n-1];
    ans.interpolated = 1'b0;
    ans.segment_index = IDX_W'(n - 1);
    found = 1'b0;
    for (int i = 0; i + 1 < n && !found; i++) begin
      x0 = bp_x[i];
      x1 = bp_x[i+1];
      y0 = bp_y[i];
      y1 = bp_y[i+1];
      if (((x0 <= qxl && qxl < x1) || (x0 >= qxl && qxl > x1)) && fll < y1) begin
        dy = y1 - y0;
        dq = qxl - x0;
        den = x1 - x0;
        mag_dy = 66'(dy < 0 ? -dy : dy);
        mag_dq = 66'(dq < 0 ? -dq : dq);
        mag_den = 66'(den < 0 ? -den : den);
        quo = (mag_dy * mag_dq) / mag_den;
        v = longint'(quo[63:0]);
        if (((dy < 0) != (dq < 0)) != (den < 0)) v = -v;
        ans.value = 32'(y0 + v);
        ans.interpolated = 1'b1;
        ans.segment_index = IDX_W'(i);
        found = 1'b1;
      end
    end
    return ans;
  endfunction

  // Present one request and hold it until accepted. On return we sit on the
  // accepting edge with start still high; the next call either re-drives it
  // or drops it, so start sees one assignment per edge.
  task automatic issue_request(input req_op_e op, input logic [IDX_W-1:0] idx,
                               input logic signed [31:0] ex, input logic signed [31:0] ey,
                               input logic signed [31:0] qx, input logic signed [31:0] fl,
                               input bit has_want, input interp_answer_t want);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) begin
      // mostly short gaps; a few long enough to land anywhere in a query scan
      gap = ($urandom_range(9) == 0) ? $urandom_range(1, 140) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_op          <= op;
    in_entry_index <= idx;
    in_entry_x     <= ex;
    in_entry_y     <= ey;
    in_query_x     <= qx;
    in_floor_value <= fl;
    do @(posedge clk); while (busy);
    if (op == OP_LOAD) begin
      bp_x[idx] = ex;
      bp_y[idx] = ey;
      entry_loaded[idx] = 1'b1;
    end else begin
      answers_due.push_back(has_want ? want : predict_interp(qx, fl));
    end
  endtask

  // Count writes only with the block idle: no query outstanding, and a
  // margin after a load just accepted.
  task automatic write_entry_count(input logic [CNT_W-1:0] cnt);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_entry_count <= cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    entry_count_q = cnt;
  endtask

  // Load entries 0..n-1 as a monotonic x run (rising or falling) with
  // random spacing; y either full range or near zero.
  task automatic shape_table(input int n);
    longint step, range, base, xv, yv;
    bit     falling;
    falling = ($urandom_range(1) != 0);
    step = 64'hFFFF_FFFF / n;
    step = step >> $urandom_range(0, 24);
    if (step < 1) step = 1;
    range = 64'h1_0000_0000 - step * n;
    base = longint'($urandom) % range;
    for (int k = 0; k < n; k++) begin
      xv = -64'sd2147483648 + base + k * step + (longint'($urandom) % step);
      if ($urandom_range(1))
        yv = longint'($urandom);
      else
        yv = longint'($urandom_range(0, 32'h000F_FFFF)) - 64'sh8_0000;
      issue_request(OP_LOAD, IDX_W'(falling ? n - 1 - k : k), 32'(xv), 32'(yv),
                    $urandom, $urandom, 1'b0, '0);
    end
  endtask

  // result checker: every strobe pairs with the oldest outstanding query
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        $error("out_valid with no query outstanding: value %h", out_value);
        mismatches++;
      end else begin
        got_want = answers_due.pop_front();
        if (out_value !== got_want.value) begin
          $error("out_value: expected %h, got %h", got_want.value, out_value);
          mismatches++;
        end
        if (out_interpolated !== got_want.interpolated) begin
          $error("out_interpolated: expected %b, got %b",
                 got_want.interpolated, out_interpolated);
          mismatches++;
        end
        if (out_segment_index !== got_want.segment_index) begin
          $error("out_segment_index: expected %0d, got %0d",
                 got_want.segment_index, out_segment_index);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t                     row;
    interp_answer_t                want;
    int                            used, seg, pick;
    longint                        x0, x1, span, qv;
    logic signed [VALUE_WIDTH-1:0] qx, fl;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = STAGE_IDLE[0];

    // directed table
    for (int r = 0; r < N_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_CFG) begin
        write_entry_count(row.cnt);
      end else begin
        want.value = row.want_value;
        want.interpolated = row.want_interp;
        want.segment_index = row.want_seg;
        issue_request(row.op, row.idx, row.ex, row.ey, row.qx, row.fl, row.has_want, want);
      end
    end

    // random phases: new count, table reshaped or topped up, then mixed requests
    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_pct = STAGE_IDLE[ph / 4];
      write_entry_count(CNT_W'(PHASE_COUNT[ph]));
      used = active_entries();
      if ($urandom_range(99) < 60) shape_table(used);
      // never query across an entry that has not been loaded
      for (int k = 0; k < used; k++) begin
        if (!entry_loaded[k])
          issue_request(OP_LOAD, IDX_W'(k), $urandom, $urandom, $urandom, $urandom,
                        1'b0, '0);
      end
      for (int it = 0; it < REQS_PER_PHASE; it++) begin
        pick = $urandom_range(99);
        if (pick < 20) begin
          // noise loads, mostly into slots beyond the entries in use
          if (used < TABLE_DEPTH && $urandom_range(99) < 70)
            seg = $urandom_range(used, TABLE_DEPTH - 1);
          else
            seg = $urandom_range(0, TABLE_DEPTH - 1);
          issue_request(OP_LOAD, IDX_W'(seg), $urandom, $urandom, $urandom, $urandom,
                        1'b0, '0);
        end else if (pick < 35 || used < 2) begin
          qx = $urandom;
          fl = ($urandom_range(3) == 0) ? MIN_Q : $urandom;
          issue_request(OP_QUERY, IDX_W'($urandom), $urandom, $urandom, qx, fl, 1'b0, '0);
        end else begin
          // aim inside a chosen segment, with the floor around its upper y
          seg = $urandom_range(0, used - 2);
          x0 = bp_x[seg];
          x1 = bp_x[seg+1];
          span = (x1 > x0) ? x1 - x0 : x0 - x1;
          if ($urandom_range(9) == 0 || span == 0)
            qv = ($urandom_range(1)) ? x0 : x1;
          else if (x1 > x0)
            qv = x0 + longint'($urandom) % span;
          else
            qv = x0 - longint'($urandom) % span;
          qx = 32'(qv);
          case ($urandom_range(3))
            0: begin
              fl = MIN_Q;
            end
            1: begin
              fl = (bp_y[seg+1] == MIN_Q) ? MIN_Q : bp_y[seg+1] - 1;
            end
            2: begin
              fl = bp_y[seg+1];
            end
            default: begin
              fl = $urandom;
            end
          endcase
          issue_request(OP_QUERY, IDX_W'($urandom), $urandom, $urandom, qx, fl, 1'b0, '0);
        end
      end
    end

    // drain: the run guard catches a query that never answers
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
